@@ design/pru_pkg.sv @@
package pru_pkg;

  // Line buffer geometry.
  localparam int MAX_WIDTH = 4096;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int COL_W     = ADDR_W + 1;

  // Register file fields.
  localparam int ROW_WIDTH_W  = 13;
  localparam int IMAGE_ROWS_W = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_ROWS = 1'd1;

  // Filter type codes carried by the first byte of each row.
  typedef enum logic [2:0] {
    FILTER_NONE    = 3'd0,
    FILTER_SUB     = 3'd1,
    FILTER_UP      = 3'd2,
    FILTER_AVERAGE = 3'd3,
    FILTER_PAETH   = 3'd4
  } filter_t;

  localparam logic [7:0] FILTER_CODE_MAX = 8'd4;

  // One word held between the input side and the result register.
  typedef struct packed {
    logic              is_filter;
    logic [7:0]        data;
    logic [ADDR_W-1:0] addr;
    logic              first_col;
    logic              has_up;
    logic              last_col;
    logic              last_row;
    filter_t           kind;
  } stage_t;

endpackage

@@ design/png_row_unfilter_8bit_unit.sv @@
// Channel   | Direction | Handshake                  | Word
// ----------+-----------+----------------------------+-----------------------------------
// data      | in        | data_valid / data_stall    | data_byte
// pixel     | out       | pixel_valid / pixel_stall  | pixel, row_end, image_end
// cfg       | in        | cfg_write (no handshake)   | cfg_index, cfg_data
//
// One word is taken per clock while data_stall is low. The edge that takes a pixel
// word loads the stage register (together with the line buffer read); the result
// register is loaded from the stage when it can take a new pixel, and drives the
// pixel channel. Filter-type words pass the stage and give no output. Reset (rst,
// synchronous) clears the row and image position, the filter type, the neighbor
// pixels and the registers (row_width and image_rows go to 1); the line buffer is
// not cleared. A pixel-channel stall holds the result register; data_stall rises
// only while a pixel waits in the stage behind a full, stalled result register.

module png_row_unfilter_8bit_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            data_valid,
  output logic                            data_stall,
  input  logic [7:0]                      data_byte,
  output logic                            pixel_valid,
  input  logic                            pixel_stall,
  output logic [7:0]                      pixel,
  output logic                            row_end,
  output logic                            image_end,
  input  logic                            cfg_write,
  input  logic [pru_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pru_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers.
  logic [pru_pkg::ROW_WIDTH_W-1:0]  row_width;
  logic [pru_pkg::IMAGE_ROWS_W-1:0] image_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width  <= pru_pkg::ROW_WIDTH_W'(1);
      image_rows <= pru_pkg::IMAGE_ROWS_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        pru_pkg::REG_ROW_WIDTH:  row_width  <= cfg_data[pru_pkg::ROW_WIDTH_W-1:0];
        pru_pkg::REG_IMAGE_ROWS: image_rows <= cfg_data[pru_pkg::IMAGE_ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes: a zero width or row count acts as one, and a width past
  // the line buffer acts as the full buffer.
  logic [pru_pkg::COL_W-1:0]        width_eff;
  logic [pru_pkg::IMAGE_ROWS_W:0]   rows_eff;

  always_comb begin
    if (row_width == '0) begin
      width_eff = pru_pkg::COL_W'(1);
    end else if (row_width > pru_pkg::ROW_WIDTH_W'(pru_pkg::MAX_WIDTH)) begin
      width_eff = pru_pkg::COL_W'(pru_pkg::MAX_WIDTH);
    end else begin
      width_eff = pru_pkg::COL_W'(row_width);
    end
    rows_eff = (image_rows == '0) ? (pru_pkg::IMAGE_ROWS_W + 1)'(1)
                                  : {1'b0, image_rows};
  end

  // Position tracking. Column 0 means the next word is a filter type; column k
  // means the next word is pixel k-1 of the row.
  logic [pru_pkg::COL_W-1:0]        column;
  logic [pru_pkg::IMAGE_ROWS_W-1:0] row_index;
  pru_pkg::filter_t                 filter_kind;

  logic                             accept;
  logic                             is_filter_word;
  logic                             last_col;
  logic                             last_row;
  logic [pru_pkg::IMAGE_ROWS_W:0]   row_plus_one;
  logic [pru_pkg::COL_W-1:0]        pixel_col;

  assign is_filter_word = (column == '0);
  assign pixel_col      = column - pru_pkg::COL_W'(1);
  assign last_col       = (column >= width_eff);
  assign row_plus_one   = {1'b0, row_index} + (pru_pkg::IMAGE_ROWS_W + 1)'(1);
  assign last_row       = (row_plus_one >= rows_eff);

  // Stage register between the input side and the result register.
  pru_pkg::stage_t stage;
  logic            stage_valid;
  logic            advance;

  // The stage empties when it holds a filter word or the result register
  // can take a new pixel.
  assign advance    = stage_valid && (stage.is_filter || !pixel_valid || !pixel_stall);
  assign data_stall = stage_valid && !advance;
  assign accept     = data_valid && !data_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      column      <= '0;
      row_index   <= '0;
      filter_kind <= pru_pkg::FILTER_NONE;
    end else if (accept) begin
      if (is_filter_word) begin
        // An unknown type is treated as none.
        filter_kind <= (data_byte <= pru_pkg::FILTER_CODE_MAX)
                       ? pru_pkg::filter_t'(data_byte[2:0]) : pru_pkg::FILTER_NONE;
        column      <= pru_pkg::COL_W'(1);
      end else if (last_col) begin
        column    <= '0;
        row_index <= last_row ? '0 : row_plus_one[pru_pkg::IMAGE_ROWS_W-1:0];
      end else begin
        column <= column + pru_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage.is_filter <= is_filter_word;
      stage.data      <= data_byte;
      stage.addr      <= pixel_col[pru_pkg::ADDR_W-1:0];
      stage.first_col <= (pixel_col == '0);
      stage.has_up    <= (row_index != '0);
      stage.last_col  <= last_col;
      stage.last_row  <= last_row;
      stage.kind      <= filter_kind;
    end
  end

  // Line buffer holding the previous reconstructed row. The read for a pixel
  // is issued as the pixel enters the stage; its data sits beside it there.
  // The same column of the previous row was written as that pixel left the
  // stage, which is always at an earlier edge because the filter word
  // in between passes through the stage on its own.
  logic [7:0] up_raw;
  logic [7:0] result;
  logic       buf_write;

  assign buf_write = advance && !stage.is_filter;

  pru_ram #(
    .WIDTH (8),
    .DEPTH (pru_pkg::MAX_WIDTH)
  ) u_line_buf (
    .clk        (clk),
    .write      (buf_write),
    .write_addr (stage.addr),
    .write_data (result),
    .read       (accept && !is_filter_word),
    .read_addr  (pixel_col[pru_pkg::ADDR_W-1:0]),
    .read_data  (up_raw)
  );

  // Neighbor pixels within the current row.
  logic [7:0] left_pixel;
  logic [7:0] upper_left_pixel;

  function automatic logic [9:0] abs_val(input logic signed [10:0] v);
    logic signed [10:0] n;
    n = v[10] ? -v : v;
    return n[9:0];
  endfunction

  // Paeth predictor in its difference form: with p = a + b - c, the distances
  // to a, b and c are |b - c|, |a - c| and |a + b - 2c|.
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic [9:0] da;
    logic [9:0] db;
    logic [9:0] dc;
    da = abs_val($signed({3'b000, b}) - $signed({3'b000, c}));
    db = abs_val($signed({3'b000, a}) - $signed({3'b000, c}));
    dc = abs_val($signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0}));
    if (da <= db && da <= dc) begin
      return a;
    end else if (db <= dc) begin
      return b;
    end
    return c;
  endfunction

  logic [7:0] up;
  logic [7:0] left;
  logic [7:0] upper_left;
  logic [8:0] sum_lu;
  logic [7:0] predictor;

  always_comb begin
    // Neighbors outside the image count as zero.
    up         = stage.has_up ? up_raw : 8'd0;
    left       = stage.first_col ? 8'd0 : left_pixel;
    upper_left = (!stage.first_col && stage.has_up) ? upper_left_pixel : 8'd0;
    sum_lu     = {1'b0, left} + {1'b0, up};
    case (stage.kind)
      pru_pkg::FILTER_SUB:     predictor = left;
      pru_pkg::FILTER_UP:      predictor = up;
      pru_pkg::FILTER_AVERAGE: predictor = sum_lu[8:1];
      pru_pkg::FILTER_PAETH:   predictor = paeth(left, up, upper_left);
      default:                 predictor = 8'd0;
    endcase
    result = stage.data + predictor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= 8'd0;
      upper_left_pixel <= 8'd0;
    end else if (buf_write) begin
      left_pixel       <= result;
      upper_left_pixel <= up;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (buf_write) begin
      pixel_valid <= 1'b1;
    end else if (!pixel_stall) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_write) begin
      pixel     <= result;
      row_end   <= stage.last_col;
      image_end <= stage.last_col && stage.last_row;
    end
  end

  // A filter word never holds up the input side.
  a_filter_drains: assert property (@(posedge clk) disable iff (rst)
    stage_valid && stage.is_filter |-> !data_stall)
    else $error("filter word held in stage");

  // A pixel behind a stalled result register stays put with its buffer data.
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !stage.is_filter && pixel_valid && pixel_stall
    |=> stage_valid && !stage.is_filter && $stable(stage) && $stable(up_raw))
    else $error("stalled pixel lost in stage");

  // The column position never runs past the line buffer.
  a_column_range: assert property (@(posedge clk) disable iff (rst)
    column <= pru_pkg::COL_W'(pru_pkg::MAX_WIDTH))
    else $error("column beyond line buffer");

endmodule

@@ design/pru_ram.sv @@
module pru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     write,
  input  logic [$clog2(DEPTH)-1:0] write_addr,
  input  logic [WIDTH-1:0]         write_data,
  input  logic                     read,
  input  logic [$clog2(DEPTH)-1:0] read_addr,
  output logic [WIDTH-1:0]         read_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (write) begin
      mem[write_addr] <= write_data;
    end
    if (read) begin
      read_data <= mem[read_addr];
    end
  end

endmodule

@@ bench/tb_png_row_unfilter_8bit_unit.sv @@
`timescale 1ns / 1ps

// Testbench for the one-byte-per-pixel PNG row unfilter.
module tb_png_row_unfilter_8bit_unit;

  // The watchdog ends the run here if the pixel stream never drains.
  localparam int CYCLE_LIMIT = 2_000_000;

  // One expected word on the pixel channel.
  typedef struct {
    logic [7:0] px;
    logic       last_in_row;
    logic       last_in_image;
  } pixel_word_t;

  // The scoreboard keeps its own copy of the line buffer, the row and image
  // position and the register values. Each accepted data word updates that
  // state and, for pixel words, queues the pixel the block should produce.
  class unfilter_scoreboard;
    logic [7:0]                       prior_row [pru_pkg::MAX_WIDTH];
    int                               column;
    int                               row_index;
    pru_pkg::filter_t                 kind;
    logic [7:0]                       left_pixel;
    logic [7:0]                       upper_left;
    logic [pru_pkg::ROW_WIDTH_W-1:0]  row_width;
    logic [pru_pkg::IMAGE_ROWS_W-1:0] image_rows;
    pixel_word_t                      expected_pixels [$];
    int                               errors;

    function new();
      foreach (prior_row[i]) prior_row[i] = 8'h00;
      column     = 0;
      row_index  = 0;
      kind       = pru_pkg::FILTER_NONE;
      left_pixel = 8'h00;
      upper_left = 8'h00;
      row_width  = 1;
      image_rows = 1;
      errors     = 0;
    endfunction

    function int eff_width();
      if (row_width == 0) return 1;
      if (row_width > pru_pkg::MAX_WIDTH) return pru_pkg::MAX_WIDTH;
      return int'(row_width);
    endfunction

    function int eff_rows();
      return (image_rows == 0) ? 1 : int'(image_rows);
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void set_register(logic [pru_pkg::CFG_INDEX_W-1:0] idx,
                               logic [pru_pkg::CFG_DATA_W-1:0] val);
      if (idx == pru_pkg::REG_ROW_WIDTH) row_width = val[pru_pkg::ROW_WIDTH_W-1:0];
      else if (idx == pru_pkg::REG_IMAGE_ROWS) image_rows = val[pru_pkg::IMAGE_ROWS_W-1:0];
    endfunction

    // Paeth picks whichever neighbor is closest to left + up - upper_left.
    function int paeth_predict(int a, int b, int c);
      int da, db, dc;
      da = (b >= c) ? b - c : c - b;
      db = (a >= c) ? a - c : c - a;
      dc = (a + b >= 2 * c) ? a + b - 2 * c : 2 * c - a - b;
      if (da <= db && da <= dc) return a;
      if (db <= dc) return b;
      return c;
    endfunction

    function void take_byte(logic [7:0] b);
      int          w, h, j, up, left, ul, add;
      logic [7:0]  res;
      pixel_word_t e;
      w = eff_width();
      h = eff_rows();
      if (column == 0) begin
        kind       = (b <= pru_pkg::FILTER_CODE_MAX) ? pru_pkg::filter_t'(b[2:0])
                                                      : pru_pkg::FILTER_NONE;
        column     = 1;
        left_pixel = 8'h00;
        upper_left = 8'h00;
        return;
      end
      j    = (column - 1 >= pru_pkg::MAX_WIDTH) ? pru_pkg::MAX_WIDTH - 1 : column - 1;
      up   = (row_index > 0) ? int'(prior_row[j]) : 0;
      left = (j > 0) ? int'(left_pixel) : 0;
      ul   = (j > 0 && row_index > 0) ? int'(upper_left) : 0;
      case (kind)
        pru_pkg::FILTER_SUB:     add = left;
        pru_pkg::FILTER_UP:      add = up;
        pru_pkg::FILTER_AVERAGE: add = (left + up) >> 1;
        pru_pkg::FILTER_PAETH:   add = paeth_predict(left, up, ul);
        default:                 add = 0;
      endcase
      res          = b + add[7:0];
      prior_row[j] = res;
      upper_left   = up[7:0];
      left_pixel   = res;
      e.px            = res;
      e.last_in_row   = (column >= w);
      e.last_in_image = (column >= w) && (row_index + 1 >= h);
      expected_pixels.push_back(e);
      if (column >= w) begin
        column    = 0;
        row_index = (row_index + 1 >= h) ? 0 : row_index + 1;
      end else begin
        column++;
      end
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
      end
    endfunction

    function void check_pixel(logic [7:0] px, logic re, logic ie);
      pixel_word_t e;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: pixel word %0h arrived with none expected", $time, px);
        return;
      end
      e = expected_pixels.pop_front();
      compare_field("pixel", e.px, px);
      compare_field("row_end", e.last_in_row, re);
      compare_field("image_end", e.last_in_image, ie);
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            data_valid;
  logic                            data_stall;
  logic [7:0]                      data_byte;
  logic                            pixel_valid;
  logic                            pixel_stall;
  logic [7:0]                      pixel;
  logic                            row_end;
  logic                            image_end;
  logic                            cfg_write;
  logic [pru_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [pru_pkg::CFG_DATA_W-1:0]  cfg_data;

  unfilter_scoreboard sb = new();

  // Words waiting to be offered on the data channel.
  logic [7:0] stream_q [$];

  // Per-phase switches for stretches with no idling on either side, and a
  // one-time long hold-off that the pixel side picks up at its next word.
  bit sender_quiet;
  bit receiver_quiet;
  int hold_cycles;
  int random_words;
  int cycle_count;

  png_row_unfilter_8bit_unit dut (
    .clk         (clk),
    .rst         (rst),
    .data_valid  (data_valid),
    .data_stall  (data_stall),
    .data_byte   (data_byte),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .row_end     (row_end),
    .image_end   (image_end),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #4 clk = ~clk;

  // The watchdog counts every cycle of the run, reset included.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Half of the words go with no wait, or all of them when quiet; the rest draw a wait.
  function automatic int draw_gap(bit quiet);
    if (quiet || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  // Pixel bytes lean toward the two extremes so that wraparound and the
  // carry out of the modulo-256 sum show up often.
  function automatic logic [7:0] rand_pixel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // Most rows use one of the five known filters; now and then an unknown
  // type byte shows up, which must behave like filter none.
  function automatic logic [7:0] rand_filter();
    if ($urandom_range(0, 7) == 0) begin
      return 8'($urandom_range(pru_pkg::FILTER_CODE_MAX + 1, 255));
    end
    return 8'($urandom_range(0, pru_pkg::FILTER_CODE_MAX));
  endfunction

  function automatic void push_row(logic [7:0] code, int n);
    stream_q.push_back(code);
    repeat (n) stream_q.push_back(rand_pixel());
  endfunction

  // Registers are written only while nothing is in flight. Through set_geometry,
  // the upper bits of a row width word are random to show the block ignores them.
  task automatic write_reg(logic [pru_pkg::CFG_INDEX_W-1:0] idx,
                           logic [pru_pkg::CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_register(idx, val);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(int w, int h);
    write_reg(pru_pkg::REG_ROW_WIDTH, {3'($urandom), 13'(w)});
    write_reg(pru_pkg::REG_IMAGE_ROWS, 16'(h));
  endtask

  // Offers every queued word in turn. Valid stays high from one word to the
  // next when the drawn wait is zero, so it is never dropped and raised in
  // the same step. A word counts as taken at the edge where stall was low.
  task automatic play_stream();
    int         gap;
    logic [7:0] b;
    while (stream_q.size() > 0) begin
      b   = stream_q.pop_front();
      gap = draw_gap(sender_quiet);
      if (gap > 0) begin
        data_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      data_valid <= 1'b1;
      data_byte  <= b;
      @(posedge clk);
      while (data_stall) @(posedge clk);
      sb.take_byte(b);
    end
    data_valid <= 1'b0;
  endtask

  // Waits for every expected pixel, then waits on so that a filter byte, which
  // gives no pixel but may still sit in the stage register, can leave it.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Pixel side. It stalls for a drawn number of cycles before each word,
  // or for the long hold-off when one is requested, then takes the next
  // word that shows up and hands it to the scoreboard.
  initial begin
    int gap;
    pixel_stall <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        gap         = hold_cycles;
        hold_cycles = 0;
      end else begin
        gap = draw_gap(receiver_quiet);
      end
      if (gap > 0) begin
        pixel_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      pixel_stall <= 1'b0;
      @(posedge clk);
      while (!pixel_valid) @(posedge clk);
      sb.check_pixel(pixel, row_end, image_end);
    end
  end

  initial begin
    int w, h, n_images;
    cycle_count    = 0;
    hold_cycles    = 0;
    random_words   = 0;
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    rst        <= 1'b1;
    data_valid <= 1'b0;
    data_byte  <= 8'h00;
    cfg_write  <= 1'b0;
    cfg_index  <= pru_pkg::REG_ROW_WIDTH;
    cfg_data   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With the reset geometry of one pixel by one row, a single pixel closes
    // both the row and the image.
    stream_q.push_back(8'(pru_pkg::FILTER_NONE));
    stream_q.push_back(8'hFF);
    play_stream();
    drain();

    // Directed rows, three pixels wide, one per filter type plus an unknown
    // type just above the last code and one at the top of the byte range.
    // Seven rows make one image, so the last pixel must carry image_end.
    set_geometry(3, 7);
    stream_q = '{8'(pru_pkg::FILTER_NONE), 8'h00, 8'hFF, 8'h5A,
                 8'(pru_pkg::FILTER_SUB), 8'hFF, 8'h01, 8'h80,
                 8'(pru_pkg::FILTER_UP), 8'h01, 8'hFF, 8'hA5,
                 8'(pru_pkg::FILTER_AVERAGE), 8'hFF, 8'hFF, 8'h10,
                 8'(pru_pkg::FILTER_PAETH), 8'h80, 8'h7F, 8'hFF,
                 pru_pkg::FILTER_CODE_MAX + 8'd1, 8'h12, 8'h34, 8'h56,
                 8'hFF, 8'hAA, 8'h55, 8'h00};
    play_stream();
    drain();

    // Geometry changed in the middle of a row and of an image. The row is
    // eight wide and the image as tall as the register allows; after five
    // pixels the width drops to three, so the sixth pixel is already past
    // the new width and must end the row.
    set_geometry(8, 65535);
    stream_q.push_back(8'(pru_pkg::FILTER_PAETH));
    repeat (5) stream_q.push_back(rand_pixel());
    play_stream();
    drain();
    write_reg(pru_pkg::REG_ROW_WIDTH, 16'd3);
    stream_q.push_back(rand_pixel());
    repeat (4) push_row(rand_filter(), 3);
    play_stream();
    drain();
    // Five rows are done; cutting the image to two rows means the next row
    // end is also the image end, and the count starts over after it.
    write_reg(pru_pkg::REG_IMAGE_ROWS, 16'd2);
    push_row(rand_filter(), 3);
    play_stream();
    drain();

    // The widest setting: a width word with every bit set is clipped to the
    // full line buffer. The second row reads the whole buffer back.
    set_geometry(8191, 2);
    push_row(8'(pru_pkg::FILTER_SUB), pru_pkg::MAX_WIDTH);
    push_row(8'(pru_pkg::FILTER_PAETH), pru_pkg::MAX_WIDTH);
    play_stream();
    drain();

    // Random phases, each a few whole images of one geometry. Widths and
    // row counts of zero act as one. The first phase also holds the pixel
    // side off for a long stretch while the data side keeps offering words,
    // so the pipeline fills and the block has to stall its input.
    while (random_words < 500) begin
      if (random_words == 0) begin
        w              = 6;
        h              = 4;
        n_images       = 2;
        sender_quiet   = 1'b1;
        receiver_quiet = 1'b0;
        hold_cycles    = 300;
      end else begin
        case ($urandom_range(0, 9))
          0:       w = 0;
          1:       w = $urandom_range(9, 40);
          default: w = $urandom_range(1, 8);
        endcase
        h              = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
        n_images       = $urandom_range(1, 3);
        sender_quiet   = ($urandom_range(0, 3) == 0);
        receiver_quiet = ($urandom_range(0, 3) == 0);
      end
      set_geometry(w, h);
      repeat (n_images * sb.eff_rows()) push_row(rand_filter(), sb.eff_width());
      random_words += stream_q.size();
      play_stream();
      drain();
    end

    // Any pixel word that shows up now has no expectation and is flagged.
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
